>>> hw/rtl/tpp_pkg.sv
// Shared types and constants for the trapezoidal position profile block.
`timescale 1ns / 1ps
package tpp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MQ_DEPTH      = 4;
  localparam int OQ_DEPTH      = 8;
  localparam int OFF_CAP_BITS  = 40;

  localparam logic [1:0] SEG_ACC = 2'd0;
  localparam logic [1:0] SEG_CRU = 2'd1;
  localparam logic [1:0] SEG_DEC = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_INFEAS = 2'd1;
  localparam logic [1:0] ST_LATE   = 2'd2;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_END   = 2'd1;
  localparam logic [1:0] REG_ACCEL = 2'd2;
  localparam logic [1:0] REG_DUR   = 2'd3;

  typedef struct packed {
    logic signed [31:0] start_pos;
    logic signed [31:0] end_pos;
    logic [30:0]        accel;
    logic [31:0]        dur;
  } cfg_t;

  typedef struct packed {
    logic        infeas;
    logic [31:0] tc;
    logic [31:0] tmt;   // duration - t_c
    logic [62:0] atc;   // accel * t_c
  } prof_t;

  typedef struct packed {
    logic [1:0]  seg;
    logic [1:0]  status;
    logic [31:0] x;     // t or duration - t for the blend parabolas
    logic [32:0] n;     // 2t - t_c for the cruise line
  } item_t;

  typedef struct packed {
    logic signed [31:0] pos;
    logic [1:0]         seg;
    logic [1:0]         status;
  } res_t;

endpackage

>>> hw/rtl/tpp_fifo.sv
// Small register queue with occupancy count.
`timescale 1ns / 1ps
module tpp_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [W-1:0]               wdata,
  input  logic                       pop,
  output logic [W-1:0]               rdata,
  output logic                       nonempty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_pop;

  assign do_pop   = pop && (cnt_r != '0);
  assign nonempty = (cnt_r != '0);
  assign count    = cnt_r;
  assign rdata    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end
endmodule

>>> hw/rtl/tpp_solver.sv
// Configuration registers and the blend-time solver (divide, square root, multiply).
`timescale 1ns / 1ps
module tpp_solver #(
  parameter int FRAC_BITS = tpp_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output tpp_pkg::cfg_t       cfg,
  output tpp_pkg::prof_t      prof,
  output logic                busy
);
  localparam int NB   = 35 + 2*FRAC_BITS;   // numerator bits: 4|D| << 2F
  localparam int CW   = $clog2(NB+1);
  localparam int CMPW = (NB+1 > 65) ? NB+1 : 65;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_SQRT  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_MUL   = 3'd6;

  tpp_pkg::cfg_t  cfg_r, cfg_nxt;
  tpp_pkg::prof_t prof_r, prof_nxt;
  logic [2:0]     st_r, st_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [NB-1:0]  num_r, num_nxt, quo_r, quo_nxt;
  logic [31:0]    rem_r, rem_nxt;
  logic [63:0]    t2_r, t2_nxt, rad_r, rad_nxt;
  logic [33:0]    srem_r, srem_nxt;
  logic [31:0]    root_r, root_nxt;

  logic signed [32:0] diff;
  logic [32:0]        mag;
  logic [31:0]        dcur;
  logic               dge;
  logic [NB:0]        qc;
  logic               over;
  logic [35:0]        scur, strial;
  logic [31:0]        tdiff;
  logic               wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid;
  assign cfg       = cfg_r;
  assign prof      = prof_r;
  assign busy      = (st_r != S_IDLE);

  always_comb begin
    diff   = 33'(signed'(cfg_r.end_pos)) - 33'(signed'(cfg_r.start_pos));
    mag    = diff[32] ? 33'(-diff) : 33'(diff);
    dcur   = {rem_r[30:0], num_r[NB-1]};
    dge    = (dcur >= {1'b0, cfg_r.accel});
    qc     = {1'b0, quo_r} + (NB+1)'(rem_r != '0);
    over   = (cfg_r.accel == '0) || (CMPW'(qc) > CMPW'(t2_r));
    scur   = {srem_r, rad_r[63:62]};
    strial = {2'b00, root_r, 2'b01};
    tdiff  = cfg_r.dur - root_r;
  end

  always_comb begin
    cfg_nxt  = cfg_r;
    prof_nxt = prof_r;
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    t2_nxt   = t2_r;
    rad_nxt  = rad_r;
    srem_nxt = srem_r;
    root_nxt = root_r;
    case (st_r)
      S_IDLE: ;
      S_START: begin
        t2_nxt  = 64'(cfg_r.dur) * 64'(cfg_r.dur);
        num_nxt = NB'({mag, 2'b00}) << (2*FRAC_BITS);
        quo_nxt = '0;
        rem_nxt = '0;
        cnt_nxt = CW'(NB);
        st_nxt  = S_DIV;
      end
      S_DIV: begin
        rem_nxt = dge ? dcur - {1'b0, cfg_r.accel} : dcur;
        quo_nxt = {quo_r[NB-2:0], dge};
        num_nxt = {num_r[NB-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          st_nxt = S_CHK;
        end
      end
      S_CHK: begin
        prof_nxt.infeas = over;
        rad_nxt  = t2_r - qc[63:0];
        srem_nxt = '0;
        root_nxt = '0;
        cnt_nxt  = CW'(32);
        st_nxt   = over ? S_IDLE : S_SQRT;
      end
      S_SQRT: begin
        if (scur >= strial) begin
          srem_nxt = 34'(scur - strial);
          root_nxt = {root_r[30:0], 1'b1};
        end else begin
          srem_nxt = scur[33:0];
          root_nxt = {root_r[30:0], 1'b0};
        end
        rad_nxt = {rad_r[61:0], 2'b00};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          st_nxt = S_FIN;
        end
      end
      S_FIN: begin
        prof_nxt.tc = {1'b0, tdiff[31:1]};
        st_nxt      = S_MUL;
      end
      S_MUL: begin
        prof_nxt.atc = 63'(cfg_r.accel) * 63'(prof_r.tc);
        prof_nxt.tmt = cfg_r.dur - prof_r.tc;
        st_nxt       = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
    if (wr) begin
      case (cfg_index)
        tpp_pkg::REG_START: cfg_nxt.start_pos = cfg_data;
        tpp_pkg::REG_END:   cfg_nxt.end_pos   = cfg_data;
        tpp_pkg::REG_ACCEL: cfg_nxt.accel     = cfg_data[30:0];
        tpp_pkg::REG_DUR:   cfg_nxt.dur       = cfg_data;
        default: ;
      endcase
      st_nxt = S_START;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_pos <= 32'sd0;
      cfg_r.end_pos   <= 32'sd205887;
      cfg_r.accel     <= 31'd1235340;
      cfg_r.dur       <= 32'd655360;
      prof_r          <= '0;
      st_r            <= S_START;
      cnt_r           <= '0;
    end else begin
      cfg_r  <= cfg_nxt;
      prof_r <= prof_nxt;
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r  <= num_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    t2_r   <= t2_nxt;
    rad_r  <= rad_nxt;
    srem_r <= srem_nxt;
    root_r <= root_nxt;
  end
endmodule

>>> hw/rtl/tpp_front.sv
// Input stage: takes sample beats and sorts them into segments.
`timescale 1ns / 1ps
module tpp_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_push,
  output logic                                   in_full,
  input  logic [31:0]                            in_sample_time,
  input  tpp_pkg::cfg_t                          cfg,
  input  tpp_pkg::prof_t                         prof,
  input  logic                                   busy,
  input  logic [$clog2(tpp_pkg::MQ_DEPTH+1)-1:0] mq_count,
  output logic                                   f_valid,
  output tpp_pkg::item_t                         f_item
);
  localparam int QCW = $clog2(tpp_pkg::MQ_DEPTH+1);

  logic           v_r, v_nxt;
  tpp_pkg::item_t it_r, it_nxt;
  logic           acc;
  logic [31:0]    t;

  // reserve a queue slot for the beat held in the stage register
  assign in_full = busy || ((mq_count + QCW'(v_r)) >= QCW'(tpp_pkg::MQ_DEPTH));
  assign acc     = in_push && !in_full;
  assign t       = in_sample_time;
  assign f_valid = v_r;
  assign f_item  = it_r;

  always_comb begin
    v_nxt     = acc;
    it_nxt.x  = t;
    it_nxt.n  = {t, 1'b0} - {1'b0, prof.tc};
    it_nxt.status = tpp_pkg::ST_OK;
    if (prof.infeas) begin
      it_nxt.seg    = tpp_pkg::SEG_ACC;
      it_nxt.status = tpp_pkg::ST_INFEAS;
    end else if (t > cfg.dur) begin
      it_nxt.seg    = tpp_pkg::SEG_DEC;
      it_nxt.status = tpp_pkg::ST_LATE;
    end else if (t <= prof.tc) begin
      it_nxt.seg = tpp_pkg::SEG_ACC;
    end else if (t <= prof.tmt) begin
      it_nxt.seg = tpp_pkg::SEG_CRU;
    end else begin
      it_nxt.seg = tpp_pkg::SEG_DEC;
      it_nxt.x   = cfg.dur - t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
    it_r <= it_nxt;
  end
endmodule

>>> hw/rtl/tpp_back.sv
// Position pipeline: square, split multiply, sum, shift/cap, signed add and saturate.
`timescale 1ns / 1ps
module tpp_back #(
  parameter int FRAC_BITS = tpp_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  tpp_pkg::cfg_t                          cfg,
  input  tpp_pkg::prof_t                         prof,
  input  logic                                   mq_nonempty,
  input  tpp_pkg::item_t                         mq_item,
  output logic                                   mq_pop,
  input  logic [$clog2(tpp_pkg::OQ_DEPTH+1)-1:0] oq_count,
  output logic                                   res_valid,
  output tpp_pkg::res_t                          res
);
  localparam int K   = 2*FRAC_BITS + 1;
  localparam int QCW = $clog2(tpp_pkg::OQ_DEPTH+1);
  localparam int OW  = tpp_pkg::OFF_CAP_BITS + 1;

  logic [5:0]  v_r;
  logic [1:0]  seg_r [5];
  logic [1:0]  sta_r [5];
  logic [31:0] x1_r;
  logic [32:0] n1_r, n2_r;
  logic [63:0] x2_r;
  logic [64:0] pl_r, ph_r;
  logic [96:0] sum_r;
  logic [OW-1:0] off_r;
  tpp_pkg::res_t res_r;

  logic [63:0]  m_sel;
  logic [32:0]  n_sel;
  logic [96:0]  shd;
  logic         neg, addit;
  logic signed [42:0] base, wide;
  logic [2:0]   infl;

  assign infl   = 3'(v_r[0]) + 3'(v_r[1]) + 3'(v_r[2]) + 3'(v_r[3]) + 3'(v_r[4]) +
                  3'(v_r[5]);
  // issue only with room in the output queue for every beat in flight
  assign mq_pop = mq_nonempty &&
                  ((QCW+1)'(oq_count) + (QCW+1)'(infl) < (QCW+1)'(tpp_pkg::OQ_DEPTH));
  assign res_valid = v_r[5];
  assign res       = res_r;

  always_comb begin
    if (seg_r[1] == tpp_pkg::SEG_CRU) begin
      m_sel = {1'b0, prof.atc};
      n_sel = n2_r;
    end else begin
      m_sel = x2_r;
      n_sel = {2'b00, cfg.accel};
    end
    shd   = sum_r >> K;
    neg   = (seg_r[4] == tpp_pkg::SEG_DEC) ^ (cfg.end_pos < cfg.start_pos);
    addit = (sta_r[4] == tpp_pkg::ST_OK) && (cfg.end_pos != cfg.start_pos);
    if (sta_r[4] == tpp_pkg::ST_INFEAS) begin
      base = 43'(cfg.start_pos);
    end else if (seg_r[4] == tpp_pkg::SEG_DEC) begin
      base = 43'(cfg.end_pos);
    end else begin
      base = 43'(cfg.start_pos);
    end
    if (!addit) begin
      wide = base;
    end else if (neg) begin
      wide = base - signed'({2'b00, off_r});
    end else begin
      wide = base + signed'({2'b00, off_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[4:0], mq_pop};
    end
    // stage 1: square of the blend time offset
    seg_r[0] <= mq_item.seg;
    sta_r[0] <= mq_item.status;
    x1_r     <= mq_item.x;
    n1_r     <= mq_item.n;
    x2_r     <= 64'(x1_r) * 64'(x1_r);
    seg_r[1] <= seg_r[0];
    sta_r[1] <= sta_r[0];
    n2_r     <= n1_r;
    // stage 2: 64 x 33 product as two halves
    pl_r     <= 65'(m_sel[31:0]) * 65'(n_sel);
    ph_r     <= 65'(m_sel[63:32]) * 65'(n_sel);
    seg_r[2] <= seg_r[1];
    sta_r[2] <= sta_r[1];
    // stage 3: recombine
    sum_r    <= 97'(pl_r) + (97'(ph_r) << 32);
    seg_r[3] <= seg_r[2];
    sta_r[3] <= sta_r[2];
    // stage 4: scale and cap the offset
    off_r    <= (shd > 97'(1'b1) << tpp_pkg::OFF_CAP_BITS) ?
                OW'(1'b1) << tpp_pkg::OFF_CAP_BITS : shd[OW-1:0];
    seg_r[4] <= seg_r[3];
    sta_r[4] <= sta_r[3];
    // stage 5: apply direction and saturate
    if (wide > 43'sd2147483647) begin
      res_r.pos <= 32'sh7FFFFFFF;
    end else if (wide < -43'sd2147483648) begin
      res_r.pos <= 32'sh80000000;
    end else begin
      res_r.pos <= wide[31:0];
    end
    res_r.seg    <= seg_r[4];
    res_r.status <= sta_r[4];
  end
endmodule

>>> hw/rtl/trapezoidal_profile_position.sv
// Top level of the trapezoidal position profile generator.
//
//  channel | handshake             | payload
//  in      | in_push / in_full     | in_sample_time
//  out     | out_pop / out_empty   | out_position, out_segment, out_status
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One sample per cycle sustained while in_full is low.
// After reset and after each cfg write, the blend-time solver runs
// (35+2*FRAC_BITS divide steps, 32 root steps if feasible) with full held high.
// Output stalls back up through the result queue and item queue to in_full.
`timescale 1ns / 1ps
module trapezoidal_profile_position #(
  parameter int FRAC_BITS = tpp_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [31:0]        in_sample_time,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_position,
  output logic [1:0]         out_segment,
  output logic [1:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  localparam int MQCW = $clog2(tpp_pkg::MQ_DEPTH+1);
  localparam int OQCW = $clog2(tpp_pkg::OQ_DEPTH+1);

  tpp_pkg::cfg_t  cfg;
  tpp_pkg::prof_t prof;
  logic           busy;
  logic           f_valid, mq_pop, mq_ne, res_valid, oq_ne;
  tpp_pkg::item_t f_item, mq_item;
  tpp_pkg::res_t  res, oq_head;
  logic [MQCW-1:0] mq_count;
  logic [OQCW-1:0] oq_count;

  tpp_solver #(.FRAC_BITS(FRAC_BITS)) u_solver (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .cfg, .prof, .busy
  );

  tpp_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_sample_time, .cfg, .prof, .busy,
    .mq_count, .f_valid, .f_item
  );

  tpp_fifo #(.W($bits(tpp_pkg::item_t)), .DEPTH(tpp_pkg::MQ_DEPTH)) u_mq (
    .clk, .rst_n, .push(f_valid), .wdata(f_item), .pop(mq_pop),
    .rdata(mq_item), .nonempty(mq_ne), .count(mq_count)
  );

  tpp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .cfg, .prof, .mq_nonempty(mq_ne), .mq_item, .mq_pop,
    .oq_count, .res_valid, .res
  );

  tpp_fifo #(.W($bits(tpp_pkg::res_t)), .DEPTH(tpp_pkg::OQ_DEPTH)) u_oq (
    .clk, .rst_n, .push(res_valid), .wdata(res), .pop(out_pop),
    .rdata(oq_head), .nonempty(oq_ne), .count(oq_count)
  );

  assign out_empty    = !oq_ne;
  assign out_position = oq_head.pos;
  assign out_segment  = oq_head.seg;
  assign out_status   = oq_head.status;
endmodule
